// ===== hdl/scale_auto_zero_tracker_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scale auto zero tracker unit.
// Each macro expands to one labeled concurrent assertion with a reset disable.
// ----------------------------------------------------------------------------
`ifndef SCALE_AUTO_ZERO_TRACKER_UNIT_ASSERT_SVH
`define SCALE_AUTO_ZERO_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SAZT_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SAZT_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sazt_pkg.sv =====
// ----------------------------------------------------------------------------
// sazt_pkg
// Types and register indexes shared by the auto zero tracker files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sazt_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_ZERO_BAND      = 3'd0;
	localparam logic [2:0] REG_MOVE_THRESHOLD = 3'd1;
	localparam logic [2:0] REG_CHECK_PERIOD   = 3'd2;
	localparam logic [2:0] REG_QUIET_TIME     = 3'd3;
	localparam logic [2:0] REG_COOLDOWN       = 3'd4;
	localparam logic [2:0] REG_UI_DELAY       = 3'd5;
	localparam logic [2:0] REG_TARE_SAMPLES   = 3'd6;
	localparam logic [2:0] REG_DISPLAY        = 3'd7;

	// One input word: one scale sample.
	typedef struct packed {
		logic [31:0]        now_ms;
		logic signed [15:0] weight_g;
		logic               stable_now;
		logic               allow_ui_msg;
		logic               clear_reminder;
	} in_word_t;

	// One result word.
	typedef struct packed {
		logic       tare_request;
		logic [7:0] tare_samples;
		logic       show_zero_msg;
		logic       ui_return_due;
	} out_word_t;

	// Configuration register file contents.
	typedef struct packed {
		logic [14:0] zero_band_g;
		logic [15:0] move_threshold_g;
		logic [31:0] stable_check_period_ms;
		logic [31:0] quiet_time_ms;
		logic [31:0] cooldown_ms;
		logic [31:0] ui_return_delay_ms;
		logic [7:0]  tare_sample_count;
		logic        display_present;
	} cfg_t;

	// Tracker state carried from sample to sample.
	typedef struct packed {
		logic signed [15:0] last_weight;
		logic [31:0]        last_move_time;
		logic [31:0]        last_zero_time;
		logic [31:0]        last_check_time;
		logic               stable_latched;
		logic [31:0]        reminder_time;
	} state_t;

endpackage

// ===== hdl/sazt_cfg.sv =====
// ----------------------------------------------------------------------------
// sazt_cfg
// Configuration registers with their reset values and a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sazt_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	output sazt_pkg::cfg_t cfg
);
	import sazt_pkg::*;

	cfg_t cfg_q;

	// Register writes; each register keeps only its own width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_band_g            <= 15'd2;
			cfg_q.move_threshold_g       <= 16'd1;
			cfg_q.stable_check_period_ms <= 32'd200;
			cfg_q.quiet_time_ms          <= 32'd3000;
			cfg_q.cooldown_ms            <= 32'd10000;
			cfg_q.ui_return_delay_ms     <= 32'd1500;
			cfg_q.tare_sample_count      <= 8'd10;
			cfg_q.display_present        <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ZERO_BAND:      cfg_q.zero_band_g            <= cfg_data[14:0];
				REG_MOVE_THRESHOLD: cfg_q.move_threshold_g       <= cfg_data[15:0];
				REG_CHECK_PERIOD:   cfg_q.stable_check_period_ms <= cfg_data;
				REG_QUIET_TIME:     cfg_q.quiet_time_ms          <= cfg_data;
				REG_COOLDOWN:       cfg_q.cooldown_ms            <= cfg_data;
				REG_UI_DELAY:       cfg_q.ui_return_delay_ms     <= cfg_data;
				REG_TARE_SAMPLES:   cfg_q.tare_sample_count      <= cfg_data[7:0];
				REG_DISPLAY:        cfg_q.display_present        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/sazt_core.sv =====
// ----------------------------------------------------------------------------
// sazt_core
// Combinational update for one sample: stability latch, movement detection,
// auto zero decision, reminder scheduling and the due test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sazt_core (
	input  sazt_pkg::in_word_t  item,
	input  sazt_pkg::cfg_t      cfg,
	input  sazt_pkg::state_t    st,
	output sazt_pkg::state_t    st_next,
	output sazt_pkg::out_word_t res
);
	import sazt_pkg::*;

	logic        chk_hit;
	logic        stable_n;
	logic [16:0] w_ext;
	logic [16:0] w_abs;
	logic        out_band;
	logic [16:0] diff;
	logic [16:0] diff_abs;
	logic        moved;
	logic        upd_weight;
	logic [31:0] move_time_n;
	logic [31:0] quiet_age;
	logic        quiet_ok;
	logic [31:0] zero_age;
	logic        zero_go;
	logic        msg;
	logic [31:0] rem_base;
	logic [31:0] rem_sched;
	logic [31:0] rem_lead;
	logic [31:0] rem_n;
	logic [31:0] rem_age;
	logic        base_due;
	logic        sched_due;

	// Stability latch once per check period, on modulo 2^32 elapsed time.
	assign chk_hit  = (item.now_ms - st.last_check_time) >= cfg.stable_check_period_ms;
	assign stable_n = chk_hit ? item.stable_now : st.stable_latched;

	// Magnitude of the weight; 17 bits hold the magnitude of the most negative value.
	assign w_ext    = {item.weight_g[15], item.weight_g};
	assign w_abs    = w_ext[16] ? (17'd0 - w_ext) : w_ext;
	assign out_band = w_abs > {2'b00, cfg.zero_band_g};

	// Jump against the last recorded weight; the magnitude stays below 2^16.
	assign diff     = w_ext - {st.last_weight[15], st.last_weight};
	assign diff_abs = diff[16] ? (17'd0 - diff) : diff;
	assign moved    = diff_abs >= {1'b0, cfg.move_threshold_g};

	assign upd_weight  = out_band || moved;
	assign move_time_n = upd_weight ? item.now_ms : st.last_move_time;

	// Quiet test runs beside the movement test: a fresh movement leaves zero
	// elapsed time, which only a zero quiet time accepts.
	assign quiet_age = item.now_ms - st.last_move_time;
	assign quiet_ok  = upd_weight ? (cfg.quiet_time_ms == 32'd0) :
		(quiet_age >= cfg.quiet_time_ms);

	// Auto zero once quiet and stable with the cooldown over, only inside the band.
	assign zero_age  = item.now_ms - st.last_zero_time;
	assign zero_go   = !out_band && quiet_ok && stable_n &&
		(zero_age >= cfg.cooldown_ms);
	assign msg       = zero_go && cfg.display_present && item.allow_ui_msg;

	// Reminder: clear first, then schedule, then test on the result. Both
	// candidates are tested in parallel; a freshly scheduled reminder lies
	// exactly the return delay ahead of the current time.
	assign rem_base  = item.clear_reminder ? 32'd0 : st.reminder_time;
	assign rem_sched = item.now_ms + cfg.ui_return_delay_ms;
	assign rem_lead  = 32'd0 - cfg.ui_return_delay_ms;
	assign rem_age   = item.now_ms - rem_base;
	assign base_due  = (rem_base != 32'd0) && !rem_age[31];
	assign sched_due = (rem_sched != 32'd0) && !rem_lead[31];
	assign rem_n     = msg ? rem_sched : rem_base;

	// Next state.
	always_comb begin
		st_next.last_check_time = chk_hit ? item.now_ms : st.last_check_time;
		st_next.stable_latched  = stable_n;
		st_next.reminder_time   = rem_n;
		st_next.last_zero_time  = zero_go ? item.now_ms : st.last_zero_time;
		st_next.last_move_time  = zero_go ? item.now_ms : move_time_n;
		if (zero_go) begin
			st_next.last_weight = 16'sd0;
		end else if (upd_weight) begin
			st_next.last_weight = item.weight_g;
		end else begin
			st_next.last_weight = st.last_weight;
		end
	end

	// Result word.
	assign res.tare_request  = zero_go;
	assign res.tare_samples  = zero_go ? cfg.tare_sample_count : 8'd0;
	assign res.show_zero_msg = msg;
	assign res.ui_return_due = msg ? sched_due : base_due;

endmodule

// ===== hdl/scale_auto_zero_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// scale_auto_zero_tracker_unit
// Automatic zero tracking for a weighing scale: one result word per sample.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   in        in_valid / in_ready    in_data  (sazt_pkg::in_word_t)
//   out       out_valid / out_ready  out_data (sazt_pkg::out_word_t)
//   cfg       cfg_we                 cfg_index, cfg_data
//
// One word is taken per cycle while in_ready is high. A word is registered
// on acceptance and passes the single update stage into the output register,
// where its result word is held with out_valid set until out_ready takes it.
// Reset clears the tracker state and both valid flags and loads the register
// reset values. When the output is stalled, one more word waits in the input
// register and in_ready drops only while both registers are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scale_auto_zero_tracker_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sazt_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sazt_pkg::out_word_t out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import sazt_pkg::*;

	cfg_t      cfg;
	in_word_t  in_s1;
	logic      vld_s1;
	out_word_t out_s2;
	logic      vld_s2;
	state_t    st_q;
	state_t    st_next;
	out_word_t res;
	logic      adv;
	logic      take;

	sazt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sazt_core u_core (
		.item    (in_s1),
		.cfg     (cfg),
		.st      (st_q),
		.st_next (st_next),
		.res     (res)
	);

	// The update stage moves whenever the output register is free or drained.
	assign adv      = !vld_s2 || out_ready;
	assign take     = vld_s1 && adv;
	assign in_ready = !vld_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// Tracker state advances once per processed word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (take) begin
			st_q <= st_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_s2 <= res;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = out_s2;

endmodule

// ===== hdl/sazt_checker.sv =====
// ----------------------------------------------------------------------------
// sazt_checker
// Port-level checks for the auto zero tracker, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "scale_auto_zero_tracker_unit_assert.svh"

module sazt_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input sazt_pkg::out_word_t out_data
);
	import sazt_pkg::*;

	// A stalled result word holds.
	`SAZT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result word changed")

	// Input back-pressure only while the output is stalled.
	`SAZT_ASSERT_NOW(a_ready_stall, clk, arst_n, !in_ready, out_valid && !out_ready, "input stalled while output free")

	// The sample count accompanies a tare request only.
	`SAZT_ASSERT_NOW(a_samples_zero, clk, arst_n, out_valid && !out_data.tare_request, out_data.tare_samples == 8'd0, "sample count without tare")

	// A zero message always comes with a tare request.
	`SAZT_ASSERT_NOW(a_msg_tare, clk, arst_n, out_valid && out_data.show_zero_msg, out_data.tare_request, "zero message without tare")

endmodule

bind scale_auto_zero_tracker_unit sazt_checker u_sazt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
